// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the packer modules.
// Each use expects clk and rst in scope; checks are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/mbp_pkg.sv -----
package mbp_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    ACT_BITS   = 2'd0,
    ACT_COINS  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Commands handed from the front to the back
  typedef enum logic [1:0] {
    CMD_STREAM = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_kind_t;

  localparam int BYTE_W      = 8;
  localparam int COINS_LEN_W = 4;
  localparam int PEND_W      = 7;
  localparam int PCNT_W      = 3;
  // Bit string length; holds the longest coins field (4 + 64)
  localparam int REM_W       = 7;

  // Padding tail: a one followed by zeros
  localparam logic [BYTE_W-1:0] PAD_PATTERN = 8'h80;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [REM_W-1:0] rem;
  } cmd_ctl_t;

endpackage

// ----- rtl/mbp_front.sv -----
module mbp_front #(
  parameter int VALUE_BITS = 64,
  localparam int LEN_MAX = (VALUE_BITS + 7) / 8,
  localparam int V8 = 8 * LEN_MAX,
  localparam int DATA_W = 4 + V8,
  localparam int SHIFT_W = $clog2(V8 + 1)
) (
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action,
  input  logic [63:0]           value,
  input  logic [6:0]            bit_count,
  input  logic                  q_full,
  output logic                  q_wr,
  output mbp_pkg::cmd_ctl_t     q_ctl,
  output logic [DATA_W-1:0]     q_data
);
  import mbp_pkg::*;

  logic [V8-1:0]      vpad;
  logic [6:0]         cnt;
  logic [3:0]         len;
  logic [SHIFT_W-1:0] sh_bits;
  logic [SHIFT_W-1:0] sh_coins;

  // Input handshake straight onto the command queue
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Masked value, saturated count and coin byte length
  always_comb begin
    vpad = '0;
    vpad[VALUE_BITS-1:0] = value[VALUE_BITS-1:0];
    if (bit_count > 7'(VALUE_BITS)) begin
      cnt = 7'(VALUE_BITS);
    end else begin
      cnt = bit_count;
    end
    len = 4'd0;
    for (int i = 0; i < LEN_MAX; i++) begin
      if (vpad[8*i +: 8] != 8'd0) begin
        len = 4'(i + 1);
      end
    end
    sh_bits  = SHIFT_W'(V8) - SHIFT_W'(cnt);
    sh_coins = SHIFT_W'(V8) - SHIFT_W'({len, 3'b000});
  end

  // Classify: every write becomes a left-aligned bit string
  always_comb begin
    q_ctl.kind = CMD_CLEAR;
    q_ctl.rem  = '0;
    q_data     = '0;
    unique case (action_t'(action))
      ACT_BITS: begin
        q_ctl.kind = CMD_STREAM;
        q_ctl.rem  = REM_W'(cnt);
        q_data     = {vpad << sh_bits, 4'b0000};
      end
      ACT_COINS: begin
        q_ctl.kind = CMD_STREAM;
        q_ctl.rem  = REM_W'({len, 3'b000}) + REM_W'(COINS_LEN_W);
        q_data     = {len, vpad << sh_coins};
      end
      ACT_FINISH: begin
        q_ctl.kind = CMD_FINISH;
      end
      ACT_CLEAR: begin
        q_ctl.kind = CMD_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/mbp_cmd_queue.sv -----
module mbp_cmd_queue #(
  parameter int DATA_W = 68
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  mbp_pkg::cmd_ctl_t wr_ctl,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd,
  output logic              rd_valid,
  output mbp_pkg::cmd_ctl_t rd_ctl,
  output logic [DATA_W-1:0] rd_data
);
  import mbp_pkg::*;

  cmd_ctl_t          ctl_q  [2];
  logic [DATA_W-1:0] data_q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_ctl   = ctl_q[rd_ptr];
  assign rd_data  = data_q[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      ctl_q[wr_ptr]  <= wr_ctl;
      data_q[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_q_write_full, wr && full, "command queue written while full")
  `ASSERT_NEVER(a_q_read_empty, rd && !rd_valid, "command queue read while empty")

endmodule

// ----- rtl/mbp_back.sv -----
module mbp_back #(
  parameter int DATA_W = 68
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mbp_pkg::cmd_ctl_t q_ctl,
  input  logic [DATA_W-1:0] q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        packed_byte,
  output logic              is_padded,
  output logic              last
);
  import mbp_pkg::*;

  // Working command
  logic              wk_valid;
  cmd_ctl_t          wk_ctl;
  logic [DATA_W-1:0] wk_data;
  // Partial byte
  logic [PEND_W-1:0] pend;
  logic [PCNT_W-1:0] pc;
  // Output register
  logic              out_valid;

  logic [3:0]        need;
  logic              slot_free;
  logic [BYTE_W-1:0] top8;
  logic [DATA_W-1:0] data_sh;
  logic [BYTE_W-1:0] top8_sh;
  logic [REM_W-1:0]  rem_left;
  logic [PCNT_W-1:0] k;
  logic [BYTE_W-1:0] win_dat;
  logic [BYTE_W-1:0] win_pad;
  logic              emit;
  logic              done;
  logic [BYTE_W-1:0] byte_val;
  logic              pad_val;
  logic              last_val;
  logic [PEND_W-1:0] pend_next;
  logic [PCNT_W-1:0] pc_next;
  logic [REM_W-1:0]  rem_next;
  logic [DATA_W-1:0] data_next;

  assign empty = !out_valid;
  assign q_rd  = q_valid && (!wk_valid || done);

  // Byte windows and shifted string
  always_comb begin
    need      = 4'd8 - {1'b0, pc};
    slot_free = !out_valid || pop;
    top8      = wk_data[DATA_W-1 -: BYTE_W];
    data_sh   = wk_data << need;
    top8_sh   = data_sh[DATA_W-1 -: BYTE_W];
    rem_left  = wk_ctl.rem - REM_W'(need);
    k         = wk_ctl.rem[PCNT_W-1:0];
    win_dat   = BYTE_W'({pend, top8} >> pc);
    win_pad   = BYTE_W'({pend, PAD_PATTERN} >> pc);
  end

  // One byte per cycle while the output register is free; the tail of a string joins the partial byte
  always_comb begin
    emit      = 1'b0;
    done      = 1'b0;
    byte_val  = win_dat;
    pad_val   = 1'b0;
    last_val  = 1'b0;
    pend_next = pend;
    pc_next   = pc;
    rem_next  = wk_ctl.rem;
    data_next = wk_data;
    if (wk_valid) begin
      unique case (wk_ctl.kind)
        CMD_CLEAR: begin
          pend_next = '0;
          pc_next   = '0;
          done      = 1'b1;
        end
        CMD_FINISH: begin
          if (pc == '0) begin
            done = 1'b1;
          end else if (slot_free) begin
            emit      = 1'b1;
            byte_val  = win_pad;
            pad_val   = 1'b1;
            last_val  = 1'b1;
            pend_next = '0;
            pc_next   = '0;
            done      = 1'b1;
          end
        end
        CMD_STREAM: begin
          if (wk_ctl.rem >= REM_W'(need)) begin
            if (slot_free) begin
              emit      = 1'b1;
              data_next = data_sh;
              rem_next  = rem_left;
              pend_next = '0;
              pc_next   = '0;
              if (rem_left < REM_W'(BYTE_W)) begin
                last_val  = 1'b1;
                done      = 1'b1;
                pc_next   = rem_left[PCNT_W-1:0];
                pend_next = PEND_W'(top8_sh >> (4'd8 - {1'b0, rem_left[PCNT_W-1:0]}));
              end
            end
          end else begin
            done      = 1'b1;
            pc_next   = pc + k;
            pend_next = PEND_W'(({1'b0, pend} << k) | (top8 >> (4'd8 - {1'b0, k})));
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // Working command and partial byte
  always_ff @(posedge clk) begin
    if (rst) begin
      wk_valid <= 1'b0;
      pend     <= '0;
      pc       <= '0;
    end else begin
      pend <= pend_next;
      pc   <= pc_next;
      if (q_rd) begin
        wk_valid <= 1'b1;
      end else if (done) begin
        wk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      wk_ctl  <= q_ctl;
      wk_data <= q_data;
    end else begin
      wk_ctl.rem <= rem_next;
      wk_data    <= data_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_byte <= byte_val;
      is_padded   <= pad_val;
      last        <= last_val;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_emit_overwrite, emit && out_valid && !pop, "byte emitted over a waiting byte")
  `ASSERT_NEVER(a_last_ends_cmd, emit && last_val && !done, "last byte without command end")
  `ASSERT_NEVER(a_end_needs_last, emit && done && !last_val, "command ended without last byte")
  `ASSERT_CLK(a_flush_pc, wk_valid && done && wk_ctl.kind != CMD_STREAM |=> pc == '0,
              "partial byte left after finish or clear")

endmodule

// ----- rtl/msb_first_bit_string_packer.sv -----
// MSB-first bit string packer.
// Input channel (push/full): one item per transfer, a transfer happens when push is
// high and full is low. action selects: write bits (low bit_count bits of value),
// write coins (4-bit byte count, then the value bytes), finish (pad a partial byte
// with a one and zeros) or clear (drop the partial byte).
// Result channel (empty/pop): completed bytes, oldest first; packed_byte carries the
// first written bit in bit 7, is_padded marks a byte closed by finish, last marks the
// final byte caused by one item. A transfer happens when pop is high and empty is low.
// Path: an item passes through the command queue, the working command register and
// the output register before its first byte is on the result ports.
// Throughput: an item holds the packing stage until its bytes are out, at most 9;
// one byte leaves per cycle while the output register is free. A two-entry command
// queue lets the input side keep taking items while the packing stage works.
// Stalls: with pop low the output register holds its byte, packing stops, the queue
// fills and full rises. Reset empties the queue and the output register and clears
// the partial byte.
module msb_first_bit_string_packer #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [63:0] value,
  input  logic [6:0]  bit_count,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  packed_byte,
  output logic        is_padded,
  output logic        last
);
  import mbp_pkg::*;

  localparam int LEN_MAX = (VALUE_BITS + 7) / 8;
  localparam int DATA_W  = 4 + 8 * LEN_MAX;

  logic              f_wr;
  cmd_ctl_t          f_ctl;
  logic [DATA_W-1:0] f_data;
  logic              q_full;
  logic              q_valid;
  logic              q_rd;
  cmd_ctl_t          q_ctl;
  logic [DATA_W-1:0] q_data;

  // Front: classify items into bit strings
  mbp_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .push      (push),
    .full      (full),
    .action    (action),
    .value     (value),
    .bit_count (bit_count),
    .q_full    (q_full),
    .q_wr      (f_wr),
    .q_ctl     (f_ctl),
    .q_data    (f_data)
  );

  // Command queue between front and back
  mbp_cmd_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (f_wr),
    .wr_ctl   (f_ctl),
    .wr_data  (f_data),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_ctl   (q_ctl),
    .rd_data  (q_data)
  );

  // Back: pack strings into bytes
  mbp_back #(
    .DATA_W (DATA_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ctl       (q_ctl),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .packed_byte (packed_byte),
    .is_padded   (is_padded),
    .last        (last)
  );

  `include "assert_macros.svh"
  `ASSERT_CLK(a_coins_len, f_wr && action_t'(action) == ACT_COINS |-> f_ctl.rem[2:0] == 3'd4,
              "coins string length not a whole number of bytes plus the count field")

endmodule
